// ----- hw/rtl/fqs_pkg.sv -----
// fqs_pkg: shared types and constants for the FIFO queue with search.
// Holds the operation codes, the sequencer state type and fixed field widths.
// No dependencies.
package fqs_pkg;

    // Operation codes carried in the func field
    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ_FRONT,
        ST_SEARCH
    } state_t;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Value returned by a dequeue that finds the queue empty
    localparam value_t DEQ_EMPTY_VALUE = -32'sd1;

endpackage

// ----- hw/rtl/fifo_queue_with_search.sv -----
// fifo_queue_with_search: ring-buffer FIFO of signed 32-bit values with
// enqueue, dequeue, search and clear. Depends on fqs_pkg.
//
//  Channel   Direction  Fields (tdata, low bit first)
//  s_axis    in         func[1:0], value[31:0], zero pad to 40 bits
//  m_axis    out        read_value[31:0], found, empty_error, full_drop,
//                       item_count[CW-1:0], front_value[31:0],
//                       back_value[31:0], is_empty, zero pad to bytes
//
// Enqueue, clear and any operation on an empty queue finish in idle; dequeue
// passes through ST_DEQ_FRONT to fetch the new front (not when it removes
// the last entry); search checks up to item_count entries, one per cycle
// through the memory's single read port. One transaction is in work at a time.
// Reset clears pointers, count and handshake state; memory contents are left.
// A stalled result holds in the output register and blocks the next input.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // func[1:0], value[33:2], pad
    input  logic [39:0]          s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // read_value, found, empty_error, full_drop, item_count, front, back, is_empty
    output logic [((100 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int PW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int RES_W  = 100 + CW;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

    // Ring pointer advance modulo DEPTH
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Input fields
    op_t    in_func;
    value_t in_value;
    logic   in_fire;

    assign in_func  = op_t'(s_tdata[FUNC_W-1:0]);
    assign in_value = s_tdata[FUNC_W+VALUE_W-1:FUNC_W];
    assign in_fire  = s_tvalid && s_tready;

    // Entry memory: one write port, one registered read port
    value_t          mem [DEPTH];
    logic            mem_we;
    logic [PW-1:0]   mem_waddr;
    value_t          mem_wdata;
    logic [PW-1:0]   mem_raddr;
    value_t          mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // Control and datapath registers
    state_t          state_reg, state_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   count_reg, count_next;
    value_t          front_reg, front_next;
    value_t          back_reg, back_next;
    value_t          hold_reg, hold_next;      // search key or dequeued value
    logic [PW-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // Result fields for the transaction that completes this cycle
    logic            emit;
    value_t          res_read;
    logic            res_found;
    logic            res_empty_err;
    logic            res_full_drop;
    logic            res_is_empty;

    logic            queue_empty;
    logic            queue_full;
    logic            scan_hit;
    logic            scan_done;

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CW'(DEPTH));
    assign scan_hit    = (mem_rdata == hold_reg);
    assign scan_done   = (scan_cnt_reg == count_reg);

    // Ready out of reset, in idle, with room in the output register
    assign s_tready = aresetn && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_func == OP_DEQ && count_reg > CW'(1)) begin
                        state_next = ST_DEQ_FRONT;
                    end else if (in_func == OP_SEARCH && !queue_empty) begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_DEQ_FRONT: begin
                state_next = ST_IDLE;
            end
            ST_SEARCH: begin
                if (scan_hit || scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result build
    always_comb begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        hold_next     = hold_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = wp_reg;
        mem_wdata     = in_value;
        mem_raddr     = scan_ptr_reg;
        emit          = 1'b0;
        res_read      = '0;
        res_found     = 1'b0;
        res_empty_err = 1'b0;
        res_full_drop = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_func)
                        OP_ENQ: begin
                            emit = 1'b1;
                            if (queue_full) begin
                                res_full_drop = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                wp_next    = ptr_inc(wp_reg);
                                count_next = count_reg + 1'b1;
                                back_next  = in_value;
                                if (queue_empty) begin
                                    front_next = in_value;
                                end
                            end
                        end
                        OP_DEQ: begin
                            if (queue_empty) begin
                                emit          = 1'b1;
                                res_empty_err = 1'b1;
                                res_read      = DEQ_EMPTY_VALUE;
                            end else begin
                                rp_next    = ptr_inc(rp_reg);
                                count_next = count_reg - 1'b1;
                                if (count_reg == CW'(1)) begin
                                    emit     = 1'b1;
                                    res_read = front_reg;
                                end else begin
                                    // fetch the new front entry
                                    mem_raddr = ptr_inc(rp_reg);
                                    hold_next = front_reg;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (queue_empty) begin
                                emit = 1'b1;
                            end else begin
                                mem_raddr     = rp_reg;
                                scan_ptr_next = ptr_inc(rp_reg);
                                scan_cnt_next = CW'(1);
                                hold_next     = in_value;
                            end
                        end
                        OP_CLEAR: begin
                            emit       = 1'b1;
                            rp_next    = '0;
                            wp_next    = '0;
                            count_next = '0;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ_FRONT: begin
                emit       = 1'b1;
                res_read   = hold_reg;
                front_next = mem_rdata;
            end
            ST_SEARCH: begin
                if (scan_hit) begin
                    emit      = 1'b1;
                    res_found = 1'b1;
                end else if (scan_done) begin
                    emit = 1'b1;
                end else begin
                    // next entry toward the back
                    mem_raddr     = scan_ptr_reg;
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase

        res_is_empty = (count_next == '0);

        // Output register load
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({
                res_is_empty,
                res_is_empty ? value_t'(0) : back_next,
                res_is_empty ? value_t'(0) : front_next,
                count_next,
                res_full_drop,
                res_empty_err,
                res_found,
                res_read
            });
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        front_reg    <= front_next;
        back_reg     <= back_next;
        hold_reg     <= hold_next;
        scan_ptr_reg <= scan_ptr_next;
        scan_cnt_reg <= scan_cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
